@@ rtl/mecal_pkg.sv @@
// ----------------------------------------------------------------------------
// mecal_pkg
// Shared constants and helpers for the median / EMA level calibrator.
// ----------------------------------------------------------------------------
`default_nettype none
package mecal_pkg;

  localparam int WIN_LEN   = 5;
  localparam int TBL_PTS   = 8;
  localparam int MED_RANK  = WIN_LEN / 2;
  localparam int WPOS_W    = (WIN_LEN > 1) ? $clog2(WIN_LEN) : 1;
  localparam int FCNT_W    = $clog2(WIN_LEN + 1);
  localparam int IDX_W     = (TBL_PTS > 1) ? $clog2(TBL_PTS) : 1;
  localparam int DIV_STEPS = 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam logic [15:0] EMA_WEIGHT_RST    = 16'd13107;
  localparam logic [15:0] CEILING_LEVEL_RST = 16'd2800;
  localparam logic [15:0] RATIO_STEP_RST    = 16'd8192;

  // Register indexes
  localparam logic [2:0] REG_EMA_WEIGHT = 3'd0;
  localparam logic [2:0] REG_CEILING    = 3'd1;
  localparam logic [2:0] REG_RATIO_STEP = 3'd2;
  localparam logic [2:0] REG_BP_LOW     = 3'd3;
  localparam logic [2:0] REG_BP_HIGH    = 3'd4;

  typedef logic [15:0] level_t;

  function automatic level_t bp_get(input logic [127:0] bps, input logic [IDX_W-1:0] k);
    logic [6:0] sh;
    sh = 7'({k, 4'b0000});
    return level_t'(bps >> sh);
  endfunction

endpackage
`default_nettype wire

@@ rtl/median_ema_level_calibrator_top.sv @@
// ----------------------------------------------------------------------------
// median_ema_level_calibrator_top
// Ring-window median, EMA smoothing and piecewise-linear fill calibration.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in_      slave      tvalid/tready      tdata[15:0] sample_ohms
// out_     master     tvalid/tready      tdata[15:0] fill_ratio, tuser filtered/above_ceiling
// cfg_     apb slave  psel/penable/pready 64-bit registers at 8*index
//
// in_tready stays low while each request is processed, plus any wait on
// out_tready: a median rank search over the WIN_LEN window entries, seed and EMA
// multiply/add states on the filtered path, a scan of up to TBL_PTS-1 breakpoints,
// and a restoring division for the 16-bit quotient. One shared 17x17 multiplier
// serves the EMA update and interpolation product. Synchronous active-low reset;
// no clearing pass. A new request is taken once the sequencer is idle, even while
// the previous result waits on out_tready.
// ----------------------------------------------------------------------------
`default_nettype none
module median_ema_level_calibrator_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] sample_ohms
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] fill_ratio
  output logic [1:0]       out_tuser,  // [0] filtered, [1] above_ceiling
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MED   = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_EMUL  = 4'd3;
  localparam logic [3:0] S_EADD  = 4'd4;
  localparam logic [3:0] S_MAP   = 4'd5;
  localparam logic [3:0] S_SCAN  = 4'd6;
  localparam logic [3:0] S_DMUL  = 4'd7;
  localparam logic [3:0] S_DINIT = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // configuration
  logic [15:0]  ema_weight_r, ceiling_r, step_r;
  logic [63:0]  bp_low_r, bp_high_r;
  logic [127:0] bps;
  logic         cfg_wr;
  logic [2:0]   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = cfg_paddr[5:3];
  assign bps        = {bp_high_r, bp_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_weight_r <= mecal_pkg::EMA_WEIGHT_RST;
      ceiling_r    <= mecal_pkg::CEILING_LEVEL_RST;
      step_r       <= mecal_pkg::RATIO_STEP_RST;
      bp_low_r     <= '0;
      bp_high_r    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mecal_pkg::REG_EMA_WEIGHT: ema_weight_r <= cfg_pwdata[15:0];
        mecal_pkg::REG_CEILING:    ceiling_r    <= cfg_pwdata[15:0];
        mecal_pkg::REG_RATIO_STEP: step_r       <= cfg_pwdata[15:0];
        mecal_pkg::REG_BP_LOW:     bp_low_r     <= cfg_pwdata;
        mecal_pkg::REG_BP_HIGH:    bp_high_r    <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mecal_pkg::REG_EMA_WEIGHT: cfg_prdata = {48'd0, ema_weight_r};
      mecal_pkg::REG_CEILING:    cfg_prdata = {48'd0, ceiling_r};
      mecal_pkg::REG_RATIO_STEP: cfg_prdata = {48'd0, step_r};
      mecal_pkg::REG_BP_LOW:     cfg_prdata = bp_low_r;
      mecal_pkg::REG_BP_HIGH:    cfg_prdata = bp_high_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // datapath state
  logic [3:0]                     state_r;
  logic [15:0]                    win_r [mecal_pkg::WIN_LEN];
  logic [mecal_pkg::WPOS_W-1:0]   wpos_r, cnt_r;
  logic [mecal_pkg::FCNT_W-1:0]   fill_r, fill_nxt;
  logic [15:0]                    ema_r, last_r, med_r, level_r, lo_r, span_r;
  logic                           started_r, filt_r;
  logic [mecal_pkg::IDX_W-1:0]    idx_r;
  logic [19:0]                    base_r;
  logic signed [33:0]             prod_r;
  logic [16:0]                    rem_r;
  logic [15:0]                    quo_r;
  logic [mecal_pkg::DCNT_W-1:0]   dcnt_r;
  logic [15:0]                    ratio_r;
  logic                           out_valid_r;
  logic [15:0]                    out_ratio_r;
  logic                           out_filt_r, out_ceil_r;

  logic                           in_acc;
  logic [mecal_pkg::FCNT_W-1:0]   rank;
  logic signed [16:0]             mul_a, mul_b;
  logic signed [33:0]             mul_p;
  logic [15:0]                    bp_first, bp_last, bp_cur, bp_next;
  logic [16:0]                    div_t;
  logic                           div_ge;
  logic [19:0]                    sum_q;
  logic [18:0]                    top_ratio;
  logic [15:0]                    probe;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign fill_nxt  = (fill_r < mecal_pkg::FCNT_W'(mecal_pkg::WIN_LEN)) ? fill_r + 1'b1 : fill_r;

  // stable rank of the candidate: smaller entries plus equal entries placed before it
  always_comb begin
    rank = '0;
    for (int j = 0; j < mecal_pkg::WIN_LEN; j++) begin
      if (win_r[j] < win_r[cnt_r] ||
          (win_r[j] == win_r[cnt_r] && mecal_pkg::WPOS_W'(j) < cnt_r))
        rank = rank + 1'b1;
    end
  end

  // shared multiplier
  always_comb begin
    if (state_r == S_EMUL) begin
      mul_a = signed'({1'b0, ema_weight_r});
      mul_b = signed'({1'b0, med_r}) - signed'({1'b0, ema_r});
    end else begin
      mul_a = signed'({1'b0, level_r - lo_r});
      mul_b = signed'({1'b0, step_r});
    end
    mul_p = mul_a * mul_b;
  end

  assign bp_first  = mecal_pkg::bp_get(bps, '0);
  assign bp_last   = mecal_pkg::bp_get(bps, mecal_pkg::IDX_W'(mecal_pkg::TBL_PTS - 1));
  assign bp_cur    = mecal_pkg::bp_get(bps, idx_r);
  assign bp_next   = mecal_pkg::bp_get(bps, idx_r + 1'b1);
  assign div_t     = {rem_r[15:0], quo_r[15]};
  assign div_ge    = (div_t >= {1'b0, span_r});
  // base plus the quotient including the bit resolved this cycle
  assign sum_q     = base_r + {4'd0, quo_r[14:0], div_ge};
  assign top_ratio = 19'(step_r) * 19'(mecal_pkg::TBL_PTS - 1);
  assign probe     = started_r ? ema_r : last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wpos_r      <= '0;
      fill_r      <= '0;
      started_r   <= 1'b0;
      ema_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < mecal_pkg::WIN_LEN; k++) win_r[k] <= '0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            win_r[wpos_r] <= in_tdata;
            last_r        <= in_tdata;
            wpos_r        <= (wpos_r == mecal_pkg::WPOS_W'(mecal_pkg::WIN_LEN - 1)) ?
                             '0 : wpos_r + 1'b1;
            fill_r        <= fill_nxt;
            cnt_r         <= '0;
            if (fill_nxt < mecal_pkg::FCNT_W'(mecal_pkg::WIN_LEN)) begin
              level_r <= in_tdata;
              filt_r  <= 1'b0;
              state_r <= S_MAP;
            end else begin
              filt_r  <= 1'b1;
              state_r <= S_MED;
            end
          end
        end
        S_MED: begin
          if (rank == mecal_pkg::FCNT_W'(mecal_pkg::MED_RANK)) med_r <= win_r[cnt_r];
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == mecal_pkg::WPOS_W'(mecal_pkg::WIN_LEN - 1)) state_r <= S_SEED;
        end
        S_SEED: begin
          if (!started_r) ema_r <= med_r;
          started_r <= 1'b1;
          state_r   <= S_EMUL;
        end
        S_EMUL: begin
          prod_r  <= mul_p;
          state_r <= S_EADD;
        end
        S_EADD: begin
          ema_r   <= ema_r + prod_r[31:16];
          level_r <= ema_r + prod_r[31:16];
          state_r <= S_MAP;
        end
        S_MAP: begin
          idx_r  <= '0;
          base_r <= '0;
          if (level_r <= bp_first) begin
            ratio_r <= '0;
            state_r <= S_OUT;
          end else if (level_r >= bp_last) begin
            ratio_r <= (top_ratio > 19'd65535) ? 16'hFFFF : top_ratio[15:0];
            state_r <= S_OUT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (level_r < bp_next) begin
            if (level_r < bp_cur) begin
              // out-of-order pair: hold the step base, no interpolation
              ratio_r <= (base_r[19:16] != 4'd0) ? 16'hFFFF : base_r[15:0];
              state_r <= S_OUT;
            end else begin
              lo_r    <= bp_cur;
              span_r  <= bp_next - bp_cur;
              state_r <= S_DMUL;
            end
          end else begin
            idx_r  <= idx_r + 1'b1;
            base_r <= base_r + {4'd0, step_r};
          end
        end
        S_DMUL: begin
          prod_r  <= mul_p;
          state_r <= S_DINIT;
        end
        S_DINIT: begin
          // quotient stays below ratio_per_step, so the high half is already below span
          rem_r   <= {1'b0, prod_r[31:16]};
          quo_r   <= prod_r[15:0];
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_ge) begin
            rem_r <= div_t - {1'b0, span_r};
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= div_t;
            quo_r <= {quo_r[14:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == mecal_pkg::DCNT_W'(mecal_pkg::DIV_STEPS - 1)) begin
            ratio_r <= (sum_q[19:16] != 4'd0) ? 16'hFFFF : sum_q[15:0];
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_ratio_r <= ratio_r;
            out_filt_r  <= filt_r;
            out_ceil_r  <= (probe >= ceiling_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ratio_r;
  assign out_tuser  = {out_ceil_r, out_filt_r};

  a_filt_started: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> started_r)
    else $error("filtered result without a seeded EMA");

  a_started_full: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (fill_r == mecal_pkg::FCNT_W'(mecal_pkg::WIN_LEN)))
    else $error("EMA seeded before window filled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("request taken while busy");

endmodule
`default_nettype wire
